// File: rtl/script_stack_alu_macros.svh
// assertion helpers for the script stack alu
`ifndef SCRIPT_STACK_ALU_MACROS_SVH
`define SCRIPT_STACK_ALU_MACROS_SVH

// same-cycle implication
`define SAS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sas_pkg.sv
package sas_pkg;

   localparam int ACTION_W = 5;
   localparam int PUSH_W   = 7;
   localparam int TOP_W    = 32;
   localparam int COUNT_W  = 7;

   // pushes take constants below this bound
   localparam logic [PUSH_W-1:0] PUSH_LIMIT = 7'd76;

   localparam int unsigned FLAG_TRUE  = 1;
   localparam int unsigned FLAG_FALSE = 0;

   typedef enum logic [ACTION_W-1:0] {
      OP_PUSH      = 5'd0,
      OP_DROP      = 5'd1,
      OP_DUP       = 5'd2,
      OP_STACK_SIZE = 5'd3,
      OP_SAME      = 5'd4,
      OP_INC       = 5'd5,
      OP_DEC       = 5'd6,
      OP_NEG       = 5'd7,
      OP_ABS       = 5'd8,
      OP_ADD       = 5'd9,
      OP_SUB       = 5'd10,
      OP_NUM_EQUAL = 5'd11,
      OP_NUM_NEQ   = 5'd12,
      OP_LESS      = 5'd13,
      OP_GREATER   = 5'd14,
      OP_LESS_EQ   = 5'd15,
      OP_GREATER_EQ = 5'd16,
      OP_MIN       = 5'd17,
      OP_MAX       = 5'd18,
      OP_IN_RANGE  = 5'd19
   } sas_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } sas_status_type;

   typedef struct packed {
      logic           wr_en;
      logic           changed;
      sas_status_type status;
   } sas_ctrl_type;

endpackage

// File: rtl/sas_req_if.sv
interface sas_req_if;
   import sas_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [PUSH_W-1:0]   push_value;

   modport source (output valid, output action, output push_value, input ready);
   modport sink   (input valid, input action, input push_value, output ready);

endinterface

// File: rtl/sas_rsp_if.sv
interface sas_rsp_if;
   import sas_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [TOP_W-1:0] top_value;
   logic [COUNT_W-1:0]      stack_count;
   sas_status_type          status;

   modport source (output valid, output top_value, output stack_count, output status,
                   input ready);
   modport sink   (input valid, input top_value, input stack_count, input status,
                   output ready);

endinterface

// File: rtl/sas_ram.sv
module sas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: rtl/sas_exec.sv
module sas_exec #(
   parameter int VALUE_WIDTH = 32,
   parameter int STACK_DEPTH = 64
) (
   input  logic [sas_pkg::ACTION_W-1:0]         action,
   input  logic [sas_pkg::PUSH_W-1:0]           push_value,
   input  logic [$clog2(STACK_DEPTH+1)-1:0]     sp,
   input  logic [VALUE_WIDTH-1:0]               opnd_a,
   input  logic [VALUE_WIDTH-1:0]               opnd_b,
   input  logic [VALUE_WIDTH-1:0]               opnd_c,
   output logic [$clog2(STACK_DEPTH+1)-1:0]     sp_next,
   output logic [VALUE_WIDTH-1:0]               top_next,
   output logic [VALUE_WIDTH-1:0]               wr_data,
   output logic [$clog2(STACK_DEPTH)-1:0]       wr_addr,
   output sas_pkg::sas_ctrl_type                ctrl
);
   import sas_pkg::*;

   localparam int PTR_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam logic [VALUE_WIDTH-1:0] TRUE_VAL  = VALUE_WIDTH'(FLAG_TRUE);
   localparam logic [VALUE_WIDTH-1:0] FALSE_VAL = VALUE_WIDTH'(FLAG_FALSE);
   localparam logic [PTR_W-1:0]       FULL      = PTR_W'(STACK_DEPTH);

   sas_op_type             op;
   logic [1:0]             need;
   logic [1:0]             pops;
   logic                   pushes;
   logic [VALUE_WIDTH-1:0] res;
   logic [PTR_W-1:0]       need_ext;
   logic [PTR_W-1:0]       pops_ext;
   logic [PTR_W-1:0]       base;
   sas_status_type         status;
   logic                   changed;

   function automatic logic lt_s(logic [VALUE_WIDTH-1:0] x, logic [VALUE_WIDTH-1:0] y);
      return $signed(x) < $signed(y);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] as_flag(logic b);
      return b ? TRUE_VAL : FALSE_VAL;
   endfunction

   always_comb begin
      op     = sas_op_type'(action);
      need   = 2'd0;
      pops   = 2'd0;
      pushes = 1'b0;
      res    = '0;
      case (op)
         OP_PUSH: begin
            if (push_value < PUSH_LIMIT) begin
               pushes = 1'b1;
               res    = VALUE_WIDTH'(push_value);
            end
         end
         OP_DROP: begin
            need = 2'd1;
            pops = 2'd1;
         end
         OP_DUP: begin
            need   = 2'd1;
            pushes = 1'b1;
            res    = opnd_a;
         end
         OP_STACK_SIZE: begin
            pushes = 1'b1;
            res    = VALUE_WIDTH'(sp);
         end
         OP_INC, OP_DEC, OP_NEG, OP_ABS: begin
            need   = 2'd1;
            pops   = 2'd1;
            pushes = 1'b1;
            case (op)
               OP_INC:    res = opnd_a + VALUE_WIDTH'(1);
               OP_DEC:    res = opnd_a - VALUE_WIDTH'(1);
               OP_NEG:    res = '0 - opnd_a;
               default:   res = opnd_a[VALUE_WIDTH-1] ? ('0 - opnd_a) : opnd_a;
            endcase
         end
         OP_SAME, OP_ADD, OP_SUB, OP_NUM_EQUAL, OP_NUM_NEQ, OP_LESS, OP_GREATER,
         OP_LESS_EQ, OP_GREATER_EQ, OP_MIN, OP_MAX: begin
            need   = 2'd2;
            pops   = 2'd2;
            pushes = 1'b1;
            case (op)
               OP_ADD:        res = opnd_b + opnd_a;
               OP_SUB:        res = opnd_b - opnd_a;
               OP_NUM_NEQ:    res = as_flag(opnd_a != opnd_b);
               OP_LESS:       res = as_flag(lt_s(opnd_b, opnd_a));
               OP_GREATER:    res = as_flag(lt_s(opnd_a, opnd_b));
               OP_LESS_EQ:    res = as_flag(!lt_s(opnd_a, opnd_b));
               OP_GREATER_EQ: res = as_flag(!lt_s(opnd_b, opnd_a));
               OP_MIN:        res = lt_s(opnd_a, opnd_b) ? opnd_a : opnd_b;
               OP_MAX:        res = lt_s(opnd_b, opnd_a) ? opnd_a : opnd_b;
               default:       res = as_flag(opnd_a == opnd_b);
            endcase
         end
         OP_IN_RANGE: begin
            need   = 2'd3;
            pops   = 2'd3;
            pushes = 1'b1;
            res    = as_flag(!lt_s(opnd_c, opnd_b) && lt_s(opnd_c, opnd_a));
         end
         default: begin
         end
      endcase

      need_ext = PTR_W'(need);
      pops_ext = PTR_W'(pops);

      if (sp < need_ext) begin
         status = ST_UNDERFLOW;
      end else if (pushes && (pops == 2'd0) && (sp >= FULL)) begin
         status = ST_OVERFLOW;
      end else begin
         status = ST_OK;
      end
      changed = (status == ST_OK) && (pushes || (pops != 2'd0));

      // new top is written to the slot of the deepest popped operand
      base     = sp - pops_ext;
      sp_next  = changed ? (base + PTR_W'(pushes)) : sp;
      wr_addr  = base[IDX_W-1:0];
      wr_data  = res;
      // a pure pop exposes the second entry
      top_next = !changed ? opnd_a : (pushes ? res : opnd_b);

      ctrl.wr_en   = changed && pushes;
      ctrl.changed = changed;
      ctrl.status  = status;
   end

endmodule

// File: rtl/script_stack_alu.sv
// an input transfer is registered, executed, and its result registered and offered on rsp_
// throughput: one item per cycle unless rsp_chan stalls; the top entry is registered and
// the next two are read each cycle from a two-port stack RAM addressed by the new depth
// reset: synchronous, active high; empties the stack and drops any held item and result
// stack entries are not cleared; only entries below the depth are ever used as operands
`include "script_stack_alu_macros.svh"

module script_stack_alu #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   sas_req_if.sink    req_chan,
   sas_rsp_if.source  rsp_chan
);
   import sas_pkg::*;

   localparam int PTR_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [ACTION_W-1:0] action_ff;
   logic [PUSH_W-1:0]   push_value_ff;

   // stack state
   logic [PTR_W-1:0]       sp_ff, sp_in;
   logic [VALUE_WIDTH-1:0] top_ff, top_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [TOP_W-1:0] rsp_top_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;
   sas_status_type          rsp_status_ff;

   logic                   exec_fire;
   logic                   req_fire;
   logic [PTR_W-1:0]       sp_next;
   logic [VALUE_WIDTH-1:0] top_next;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]       wr_addr;
   sas_ctrl_type           ctrl;
   logic [VALUE_WIDTH-1:0] rd_data_a;
   logic [VALUE_WIDTH-1:0] rd_data_b;
   logic [PTR_W-1:0]       rd_ptr_a;
   logic [PTR_W-1:0]       rd_ptr_b;
   logic [IDX_W-1:0]       rd_addr_a;
   logic [IDX_W-1:0]       rd_addr_b;

   assign exec_fire = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || exec_fire;

   sas_exec #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_exec (
      .action     (action_ff),
      .push_value (push_value_ff),
      .sp         (sp_ff),
      .opnd_a     (top_ff),
      .opnd_b     (rd_data_a),
      .opnd_c     (rd_data_b),
      .sp_next    (sp_next),
      .top_next   (top_next),
      .wr_data    (wr_data),
      .wr_addr    (wr_addr),
      .ctrl       (ctrl)
   );

   assign sp_in  = exec_fire ? sp_next : sp_ff;
   assign top_in = exec_fire ? top_next : top_ff;

   // fetch the second and third entries of the depth that holds after this cycle
   assign rd_ptr_a  = sp_in - PTR_W'(2);
   assign rd_ptr_b  = sp_in - PTR_W'(3);
   assign rd_addr_a = (sp_in >= PTR_W'(2)) ? rd_ptr_a[IDX_W-1:0] : '0;
   assign rd_addr_b = (sp_in >= PTR_W'(3)) ? rd_ptr_b[IDX_W-1:0] : '0;

   sas_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock     (clock),
      .wr_en     (exec_fire && ctrl.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign in_valid_in  = req_fire || (in_valid_ff && !exec_fire);
   assign rsp_valid_in = exec_fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (req_fire) begin
         action_ff     <= req_chan.action;
         push_value_ff <= req_chan.push_value;
      end
      if (exec_fire) begin
         rsp_top_ff    <= (sp_next == '0) ? '0 : TOP_W'($signed(top_next));
         rsp_count_ff  <= COUNT_W'(sp_next);
         rsp_status_ff <= ctrl.status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.top_value   = rsp_top_ff;
   assign rsp_chan.stack_count = rsp_count_ff;
   assign rsp_chan.status      = rsp_status_ff;

   `SAS_ASSERT_IMP(a_sp_bound, clock, reset, 1'b1, sp_ff <= PTR_W'(STACK_DEPTH), "depth beyond stack size")
   `SAS_ASSERT_NXT(a_err_keeps_sp, clock, reset, exec_fire && (ctrl.status != ST_OK), sp_ff == $past(sp_ff), "failed step moved the depth")
   `SAS_ASSERT_NXT(a_count_tracks, clock, reset, exec_fire, rsp_valid_ff && (rsp_count_ff == COUNT_W'(sp_ff)), "reported count differs from depth")
   `SAS_ASSERT_NXT(a_empty_top, clock, reset, exec_fire && (sp_next == '0), rsp_top_ff == '0, "empty stack reports a nonzero top")

endmodule
